FILE: sv/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the min-priority queue and its cell row.
// ---------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEPTH   = 64;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
    } cell_cmd_t;

endpackage

FILE: sv/binary_min_heap_queue.sv
// ---------------------------------------------------------------------------
// binary_min_heap_queue
// Min-priority queue of signed keys held sorted in a row of cells; insert
// opens a slot by shifting larger keys right, remove shifts the row left.
// ---------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser
//  s_*       in   [31:0] key_in                          [0] func
//  m_*       out  [31:0] min_out, [38:32] count_after    [1:0] status
//
//  one transaction per cycle while m_tready is high: a result appears the cycle after acceptance
//  every cell of the row updates at the same edge
//  s_tready is high while the output register is empty or being taken
//  reset empties the queue; no clearing pass is needed
// ---------------------------------------------------------------------------
module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_in
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] min_out, [38:32] count_after, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [KEY_W-1:0]   min_reg;
    logic [KEY_W-1:0]   min_next;
    status_t            status_reg;
    status_t            status_next;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic [COUNT_W-1:0] cnt_out_next;

    logic               in_acc;
    func_t              func;
    cell_cmd_t          cmd;

    logic [KEY_W-1:0]   cell_key [DEPTH];
    logic [DEPTH-1:0]   cell_occ;
    logic [DEPTH-1:0]   cell_le;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser[0]);

    always_comb
    begin
        cmd.key = s_tdata;
        cmd.ins = in_acc && (func == FUNC_INSERT) && (count_reg != DEPTH_CNT);
        cmd.rem = in_acc && (func == FUNC_REMOVE) && (count_reg != '0);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0] lkey;
            logic             lle;
            logic             locc;
            logic [KEY_W-1:0] rkey;
            logic             rocc;
            if (gi == 0)
            begin : g_first
                assign lkey = '0;
                assign lle  = 1'b1;
                assign locc = 1'b0;
            end
            else
            begin : g_mid_l
                assign lkey = cell_key[gi-1];
                assign lle  = cell_le[gi-1];
                assign locc = cell_occ[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign rkey = '0;
                assign rocc = 1'b0;
            end
            else
            begin : g_mid_r
                assign rkey = cell_key[gi+1];
                assign rocc = cell_occ[gi+1];
            end
            bmhq_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left_key  (lkey),
                .left_le   (lle),
                .left_occ  (locc),
                .right_key (rkey),
                .right_occ (rocc),
                .key       (cell_key[gi]),
                .occ       (cell_occ[gi]),
                .le        (cell_le[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        min_next       = min_reg;
        status_next    = status_reg;
        cnt_out_next   = cnt_out_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            min_next       = '0;
            status_next    = STATUS_OK;
            unique case (func)
                FUNC_INSERT:
                begin
                    if (count_reg == DEPTH_CNT)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                FUNC_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        min_next   = cell_key[0];
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
            cnt_out_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg     <= min_next;
        status_reg  <= status_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40 - KEY_W - COUNT_W){1'b0}}, cnt_out_reg, min_reg};
    assign m_tuser  = status_reg;

    // occupied cells always match the key count
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_occ) == 32'(count_reg))
        else $error("cell occupancy disagrees with key count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("key count above depth");

    // a successful remove gives up exactly one key
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("remove did not decrement count");

    // the first two occupied cells of the row stay in order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[1] |-> $signed(cell_key[0]) <= $signed(cell_key[1]))
        else $error("head of row out of order");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STATUS_OK) |-> min_reg == '0)
        else $error("error result carries a key");

endmodule

FILE: sv/bmhq_cell.sv
// ---------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted key row: keeps its key, takes the new key or its
// left neighbor's key on insert, and its right neighbor's key on remove.
// ---------------------------------------------------------------------------
module bmhq_cell
    import bmhq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [KEY_W-1:0] left_key,
    input  logic             left_le,
    input  logic             left_occ,
    input  logic [KEY_W-1:0] right_key,
    input  logic             right_occ,
    output logic [KEY_W-1:0] key,
    output logic             occ,
    output logic             le
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             occ_reg;
    logic             occ_next;

    // this slot holds a key no larger than the one being inserted
    assign le = occ_reg && ($signed(key_reg) <= $signed(cmd.key));

    always_comb
    begin
        key_next = key_reg;
        occ_next = occ_reg;
        if (cmd.rem)
        begin
            key_next = right_key;
            occ_next = right_occ;
        end
        else if (cmd.ins && !le)
        begin
            if (left_le)
            begin
                // new key lands here
                key_next = cmd.key;
                occ_next = 1'b1;
            end
            else
            begin
                // shift one slot to the right
                key_next = left_key;
                occ_next = left_occ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;
    assign occ = occ_reg;

endmodule
